/* src/sbx_pkg.sv */
`default_nettype none
package sbx_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;

    localparam int CMD_W  = 3;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 9;
    localparam int MODE_W = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SEND  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RECV  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EVENT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    localparam logic [MODE_W-1:0] MODE_MASTER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SLAVE  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic clear_step;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic needs_clear;
        logic clear_last;
    } dp_status_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

endpackage
`default_nettype wire

/* src/sbx_ram.sv */
`default_nettype none
module sbx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* src/sbx_ctrl.sv */
`default_nettype none
module sbx_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sbx_pkg::dp_status_t dp_status,
    output sbx_pkg::ctrl_cmd_t      ctrl_cmd
);

    sbx_pkg::state_t state_reg;
    sbx_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbx_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        in_ready            = 1'b0;
        ctrl_cmd.capture    = 1'b0;
        ctrl_cmd.execute    = 1'b0;
        ctrl_cmd.clear_step = 1'b0;
        case (state_reg)
            sbx_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl_cmd.capture = 1'b1;
                    state_next       = sbx_pkg::ST_EXEC;
                end
            end
            sbx_pkg::ST_EXEC:
            begin
                // hold the read data until the result register has room
                if (dp_status.out_free)
                begin
                    ctrl_cmd.execute = 1'b1;
                    state_next = dp_status.needs_clear ? sbx_pkg::ST_CLEAR : sbx_pkg::ST_IDLE;
                end
            end
            sbx_pkg::ST_CLEAR:
            begin
                ctrl_cmd.clear_step = 1'b1;
                if (dp_status.clear_last)
                begin
                    state_next = sbx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbx_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/sbx_datapath.sv */
`default_nettype none
module sbx_datapath #(
    parameter int BUFFER_DEPTH = sbx_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sbx_pkg::ctrl_cmd_t           ctrl_cmd,
    output sbx_pkg::dp_status_t               dp_status,
    input  wire logic                         cfg_wr_en,
    input  wire logic [sbx_pkg::MODE_W-1:0]   cfg_wr_data,
    input  wire logic [sbx_pkg::CMD_W-1:0]    command,
    input  wire logic [sbx_pkg::BYTE_W-1:0]   entry_index,
    input  wire logic [sbx_pkg::BYTE_W-1:0]   entry_data,
    input  wire logic [sbx_pkg::LEN_W-1:0]    length,
    input  wire logic [sbx_pkg::BYTE_W-1:0]   rx_byte,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              tx_valid,
    output logic      [sbx_pkg::BYTE_W-1:0]   tx_byte,
    output logic                              done_res,
    output logic      [sbx_pkg::BYTE_W-1:0]   read_data,
    output logic                              status
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int PW = (AW > sbx_pkg::LEN_W) ? AW : sbx_pkg::LEN_W;
    localparam logic [31:0] DEPTH32 = 32'(BUFFER_DEPTH);

    // captured transaction
    logic [sbx_pkg::CMD_W-1:0]  cmd_reg;
    logic [sbx_pkg::BYTE_W-1:0] idx_reg;
    logic [sbx_pkg::BYTE_W-1:0] data_reg;
    logic [sbx_pkg::LEN_W-1:0]  len_reg;
    logic [sbx_pkg::BYTE_W-1:0] rx_reg;

    // engine state
    logic [sbx_pkg::MODE_W-1:0] mode_reg;
    logic [sbx_pkg::LEN_W-1:0]  pos_reg, pos_next;
    logic [sbx_pkg::LEN_W-1:0]  tlen_reg, tlen_next;
    logic                       busy_reg, busy_next;
    logic                       ready_reg, ready_next;
    logic                       zero_fill_reg, zero_fill_next;
    logic [sbx_pkg::LEN_W-1:0]  clr_cnt_reg;

    // result register
    logic                       out_valid_reg;
    logic                       txv_reg, txv_next;
    logic [sbx_pkg::BYTE_W-1:0] txb_reg, txb_next;
    logic                       done_reg;
    logic [sbx_pkg::BYTE_W-1:0] rd_reg, rd_next;
    logic                       st_reg, st_next;

    // memory port signals
    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [sbx_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;
    logic                       ex_we;
    logic [PW-1:0]              ex_waddr_w, raddr_w, clr_addr_w;
    logic [sbx_pkg::BYTE_W-1:0] ex_wdata;

    logic [sbx_pkg::LEN_W-1:0]  len_sat;
    logic [sbx_pkg::LEN_W-1:0]  pos_inc;
    logic                       idx_ok, in_idx_ok;
    logic                       is_master, is_slave;

    assign is_master = (mode_reg == sbx_pkg::MODE_MASTER);
    assign is_slave  = (mode_reg == sbx_pkg::MODE_SLAVE);
    assign pos_inc   = pos_reg + sbx_pkg::LEN_W'(1);
    assign len_sat   = (32'(len_reg) > DEPTH32) ? sbx_pkg::LEN_W'(BUFFER_DEPTH) : len_reg;
    assign idx_ok    = 32'(idx_reg) < DEPTH32;
    assign in_idx_ok = 32'(entry_index) < DEPTH32;

    // read issue, at capture time from the live input fields
    always_comb
    begin
        raddr_w = '0;
        case (command)
            sbx_pkg::CMD_READ:  raddr_w = in_idx_ok ? PW'(entry_index) : '0;
            // master prefetches the byte after the one being stored
            sbx_pkg::CMD_EVENT: raddr_w = is_master ? PW'(pos_inc) : PW'(pos_reg);
            default:            raddr_w = '0;
        endcase
    end

    assign ram_re    = ctrl_cmd.capture;
    assign ram_raddr = raddr_w[AW-1:0];

    // execute
    always_comb
    begin
        pos_next       = pos_reg;
        tlen_next      = tlen_reg;
        busy_next      = busy_reg;
        ready_next     = ready_reg;
        zero_fill_next = zero_fill_reg;
        txv_next       = 1'b0;
        txb_next       = '0;
        rd_next        = '0;
        st_next        = 1'b0;
        ex_we          = 1'b0;
        ex_waddr_w     = '0;
        ex_wdata       = '0;
        case (cmd_reg)
            sbx_pkg::CMD_LOAD:
            begin
                ex_we      = idx_ok;
                ex_waddr_w = PW'(idx_reg);
                ex_wdata   = data_reg;
            end
            sbx_pkg::CMD_SEND, sbx_pkg::CMD_RECV:
            begin
                zero_fill_next = (cmd_reg == sbx_pkg::CMD_RECV);
                tlen_next      = len_sat;
                pos_next       = '0;
                if (len_sat == '0)
                begin
                    ready_next = 1'b1;
                    busy_next  = 1'b0;
                end
                else
                begin
                    ready_next = 1'b0;
                    busy_next  = 1'b1;
                    if (is_master)
                    begin
                        txv_next = 1'b1;
                        // receive start sends the zeroed first entry
                        txb_next = zero_fill_next ? '0 : ram_rdata;
                    end
                end
            end
            sbx_pkg::CMD_EVENT:
            begin
                if (!busy_reg || !(is_master || is_slave))
                begin
                    st_next = 1'b1;
                end
                else
                begin
                    ex_we      = 1'b1;
                    ex_waddr_w = PW'(pos_reg);
                    ex_wdata   = rx_reg;
                    pos_next   = pos_inc;
                    if (is_slave)
                    begin
                        txv_next = 1'b1;
                        txb_next = ram_rdata;
                    end
                    if (pos_inc < tlen_reg)
                    begin
                        if (is_master)
                        begin
                            txv_next = 1'b1;
                            txb_next = ram_rdata;
                        end
                    end
                    else
                    begin
                        ready_next = 1'b1;
                        busy_next  = 1'b0;
                    end
                end
            end
            sbx_pkg::CMD_READ:
            begin
                rd_next = idx_ok ? ram_rdata : '0;
            end
            default:
            begin
            end
        endcase
    end

    assign clr_addr_w = PW'(clr_cnt_reg);

    always_comb
    begin
        if (ctrl_cmd.clear_step)
        begin
            ram_we    = zero_fill_reg;
            ram_waddr = clr_addr_w[AW-1:0];
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = ctrl_cmd.execute & ex_we;
            ram_waddr = ex_waddr_w[AW-1:0];
            ram_wdata = ex_wdata;
        end
    end

    sbx_ram #(
        .WIDTH (sbx_pkg::BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // captured fields and result fields, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.capture)
        begin
            cmd_reg  <= command;
            idx_reg  <= entry_index;
            data_reg <= entry_data;
            len_reg  <= length;
            rx_reg   <= rx_byte;
        end
        if (ctrl_cmd.execute)
        begin
            txv_reg <= txv_next;
            txb_reg <= txb_next;
            rd_reg  <= rd_next;
            st_reg  <= st_next;
            done_reg <= ready_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            pos_reg       <= '0;
            tlen_reg      <= '0;
            busy_reg      <= 1'b0;
            ready_reg     <= 1'b0;
            zero_fill_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (ctrl_cmd.execute)
            begin
                pos_reg       <= pos_next;
                tlen_reg      <= tlen_next;
                busy_reg      <= busy_next;
                ready_reg     <= ready_next;
                zero_fill_reg <= zero_fill_next;
                clr_cnt_reg   <= '0;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                if (out_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
                if (ctrl_cmd.clear_step)
                begin
                    clr_cnt_reg <= clr_cnt_reg + sbx_pkg::LEN_W'(1);
                end
            end
        end
    end

    assign dp_status.out_free    = !out_valid_reg || out_ready;
    assign dp_status.needs_clear = (cmd_reg == sbx_pkg::CMD_RECV) && (len_sat != '0);
    assign dp_status.clear_last  = (clr_cnt_reg + sbx_pkg::LEN_W'(1)) == tlen_reg;

    assign out_valid = out_valid_reg;
    assign tx_valid  = txv_reg;
    assign tx_byte   = txb_reg;
    assign done_res  = done_reg;
    assign read_data = rd_reg;
    assign status    = st_reg;

endmodule
`default_nettype wire

/* src/spi_buffer_exchange_engine_top.sv */
// An accepted transaction executes once the result register has room; the
// next is accepted after that or, for a start-receive of length L, after a
// zeroing sweep of entries 0..min(L,BUFFER_DEPTH)-1 (one write port). A
// finished result waits in an output register while the next is accepted.
// Reset (rst_n, async, active low) clears mode, position, length and flags;
// buffer contents are undefined until loaded.
`default_nettype none
module spi_buffer_exchange_engine_top #(
    parameter int BUFFER_DEPTH = sbx_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [sbx_pkg::MODE_W-1:0] cfg_wr_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [sbx_pkg::CMD_W-1:0]  command,
    input  wire logic [sbx_pkg::BYTE_W-1:0] entry_index,
    input  wire logic [sbx_pkg::BYTE_W-1:0] entry_data,
    input  wire logic [sbx_pkg::LEN_W-1:0]  length,
    input  wire logic [sbx_pkg::BYTE_W-1:0] rx_byte,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            tx_valid,
    output logic      [sbx_pkg::BYTE_W-1:0] tx_byte,
    output logic                            done_res,
    output logic      [sbx_pkg::BYTE_W-1:0] read_data,
    output logic                            status
);

    sbx_pkg::ctrl_cmd_t  ctrl_cmd;
    sbx_pkg::dp_status_t dp_status;

    sbx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    sbx_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl_cmd    (ctrl_cmd),
        .dp_status   (dp_status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .command     (command),
        .entry_index (entry_index),
        .entry_data  (entry_data),
        .length      (length),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .done_res    (done_res),
        .read_data   (read_data),
        .status      (status)
    );

endmodule
`default_nettype wire
